@@ rtl/roulette_wheel_selector_defines.svh @@
// ----------------------------------------------------------------------------
// roulette_wheel_selector_defines
// Assertion macros used by the selector top level.
// ----------------------------------------------------------------------------
`ifndef ROULETTE_WHEEL_SELECTOR_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTOR_DEFINES_SVH

// Clocked check, held off while reset is high.
`define RWS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("roulette_wheel_selector: assertion failed");

// Clocked check that also holds during reset.
`define RWS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("roulette_wheel_selector: assertion failed");

`endif

@@ rtl/rws_pkg.sv @@
// ----------------------------------------------------------------------------
// rws_pkg
// Types and codes shared by the roulette wheel selector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rws_pkg;

   localparam int FIT_W    = 16;
   localparam int FRAC_W   = 16;
   localparam int SLOT_W   = 6;
   localparam int TOTAL_W  = 22;
   localparam int TARGET_W = FRAC_W + TOTAL_W;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PICK = 1'b1;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_ZERO_TOTAL = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0] picked_index;
      logic              status;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/rws_fit_mem.sv @@
// ----------------------------------------------------------------------------
// rws_fit_mem
// Fitness store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_fit_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [rws_pkg::FIT_W-1:0]  wr_data,
   input  wire logic                       rd_en,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   output logic      [rws_pkg::FIT_W-1:0]  rd_data_ff
);

   logic [rws_pkg::FIT_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/rws_engine.sv @@
// ----------------------------------------------------------------------------
// rws_engine
// Sequencer: clears the store, does load read-modify-write, scans for picks.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_engine #(
   parameter int POP_SIZE = 64,
   parameter int ADDR_W   = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic                          in_op,
   input  wire logic [rws_pkg::SLOT_W-1:0]    in_slot,
   input  wire logic [rws_pkg::FIT_W-1:0]     in_fit,
   input  wire logic [rws_pkg::FRAC_W-1:0]    in_frac,
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output rws_pkg::result_type                res,
   output logic                               mem_wr_en,
   output logic [ADDR_W-1:0]                  mem_wr_addr,
   output logic [rws_pkg::FIT_W-1:0]          mem_wr_data,
   output logic                               mem_rd_en,
   output logic [ADDR_W-1:0]                  mem_rd_addr,
   input  wire logic [rws_pkg::FIT_W-1:0]     mem_rd_data
);

   localparam int CUM_W = rws_pkg::FIT_W + ADDR_W;
   localparam int CMP_W = (CUM_W + 16 > rws_pkg::TARGET_W) ? CUM_W + 16 : rws_pkg::TARGET_W;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(POP_SIZE - 1);

   rws_pkg::state_type state_ff, state_in;
   logic [rws_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [ADDR_W-1:0]            idx_ff, idx_in;
   logic [CUM_W-1:0]             cum_ff, cum_in;
   logic [rws_pkg::TARGET_W-1:0] target_ff, target_in;
   logic [ADDR_W-1:0]            slot_ff, slot_in;
   logic [rws_pkg::FIT_W-1:0]    fit_ff, fit_in;
   rws_pkg::result_type          res_ff, res_in;

   logic [CUM_W-1:0] cum_next;
   logic             hit;
   logic             slot_ok;

   assign cum_next = cum_ff + CUM_W'(mem_rd_data);
   assign hit      = CMP_W'({cum_next, 16'h0000}) >= CMP_W'(target_ff);
   assign slot_ok  = 32'(in_slot) < 32'(POP_SIZE);
   assign res      = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rws_pkg::ST_CLEAR;
         total_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cum_ff    <= cum_in;
      target_ff <= target_in;
      slot_ff   <= slot_in;
      fit_ff    <= fit_in;
      res_ff    <= res_in;
   end

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      idx_in      = idx_ff;
      cum_in      = cum_ff;
      target_in   = target_ff;
      slot_in     = slot_ff;
      fit_in      = fit_ff;
      res_in      = res_ff;
      in_ready    = 1'b0;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = slot_ff;
      mem_wr_data = fit_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ADDR_W'(in_slot);

      case (state_ff)
         rws_pkg::ST_CLEAR: begin
            // one entry per cycle after reset
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff;
            mem_wr_data = '0;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = rws_pkg::ST_IDLE;
            end
         end
         rws_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               res_in.picked_index = '0;
               res_in.status       = rws_pkg::STATUS_OK;
               if (in_op == rws_pkg::OP_LOAD) begin
                  slot_in = ADDR_W'(in_slot);
                  fit_in  = in_fit;
                  if (slot_ok) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = ADDR_W'(in_slot);
                     state_in    = rws_pkg::ST_LOAD;
                  end else begin
                     state_in = rws_pkg::ST_REPLY;
                  end
               end else if (total_ff == '0) begin
                  res_in.status = rws_pkg::STATUS_ZERO_TOTAL;
                  state_in      = rws_pkg::ST_REPLY;
               end else begin
                  target_in   = rws_pkg::TARGET_W'(in_frac) * rws_pkg::TARGET_W'(total_ff);
                  cum_in      = '0;
                  idx_in      = '0;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  state_in    = rws_pkg::ST_SCAN;
               end
            end
         end
         rws_pkg::ST_LOAD: begin
            // old value is on the read port now
            mem_wr_en = 1'b1;
            total_in  = total_ff - rws_pkg::TOTAL_W'(mem_rd_data)
                        + rws_pkg::TOTAL_W'(fit_ff);
            state_in  = rws_pkg::ST_REPLY;
         end
         rws_pkg::ST_SCAN: begin
            // read data holds entry idx_ff; next entry is fetched alongside
            if (hit || idx_ff == LAST_IDX) begin
               res_in.picked_index = rws_pkg::SLOT_W'(idx_ff);
               res_in.status       = rws_pkg::STATUS_OK;
               state_in            = rws_pkg::ST_REPLY;
            end else begin
               cum_in      = cum_next;
               idx_in      = idx_ff + 1'b1;
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff + 1'b1;
            end
         end
         rws_pkg::ST_REPLY: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = rws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rws_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/roulette_wheel_selector.sv @@
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// Fitness-proportionate selection over a population held in one memory.
// ----------------------------------------------------------------------------
// After reset the fitness memory is cleared one entry a cycle, during
// which req_tready stays low. A load word reads the old fitness, then
// writes the new one and adjusts the total. A pick word scans the store
// from index 0 one entry per cycle through the single read port, up to
// the first entry whose running sum reaches the target or the last entry.
// A pick with zero total, or a load to a slot beyond the population, goes
// to its result without touching the store. One word is worked on at a
// time; the result register lets the next word in while a result still
// waits on rsp_tready.
`default_nettype none

`include "roulette_wheel_selector_defines.svh"

module roulette_wheel_selector #(
   parameter int POP_SIZE = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [5:0] slot, [21:6] fitness_value, [37:22] random_fraction, [39:38] zero
   input  wire logic [39:0] req_tdata,
   // [0] op
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [5:0] picked_index, [7:6] zero
   output logic [7:0]       rsp_tdata,
   // [0] status
   output logic             rsp_tuser
);

   localparam int ADDR_W = $clog2(POP_SIZE);

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [rws_pkg::FIT_W-1:0]   wr_data;
   logic                        rd_en;
   logic [ADDR_W-1:0]           rd_addr;
   logic [rws_pkg::FIT_W-1:0]   rd_data;

   logic                        res_valid;
   logic                        res_ready;
   rws_pkg::result_type         res;

   logic                        rsp_valid_ff;
   rws_pkg::result_type         rsp_ff;

   rws_fit_mem #(
      .DEPTH  (POP_SIZE),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   rws_engine #(
      .POP_SIZE (POP_SIZE),
      .ADDR_W   (ADDR_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_op       (req_tuser),
      .in_slot     (req_tdata[5:0]),
      .in_fit      (req_tdata[21:6]),
      .in_frac     (req_tdata[37:22]),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (wr_en),
      .mem_wr_addr (wr_addr),
      .mem_wr_data (wr_data),
      .mem_rd_en   (rd_en),
      .mem_rd_addr (rd_addr),
      .mem_rd_data (rd_data)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.picked_index};
   assign rsp_tuser  = rsp_ff.status;

   `RWS_ASSERT(a_one_word_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `RWS_ASSERT(a_handoff_lands, clock, reset, res_valid && res_ready |=> rsp_tvalid)
   `RWS_ASSERT(a_refused_index_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'h00)
   `RWS_ASSERT_ALWAYS(a_idle_in_reset, clock, reset |=> !req_tready && !rsp_tvalid)

endmodule

`default_nettype wire
